// ----- sv/wsfd_pkg.sv -----
`default_nettype none
package wsfd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [2:0] KEY_LAST = 3'd3;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  header_bits;
		logic        mask_flag;
		logic [63:0] remaining_length;
		logic [2:0]  field_byte_count;
		logic [31:0] mask_key;
		logic [1:0]  key_index;
	} wsfd_state_t;

	localparam wsfd_state_t STATE_RESET = '{
		phase: PH_HDR0,
		header_bits: 8'd0,
		mask_flag: 1'b0,
		remaining_length: 64'd0,
		field_byte_count: 3'd0,
		mask_key: 32'd0,
		key_index: 2'd0
	};

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       final_fragment;
		logic [2:0] reserved_bits;
		logic [3:0] frame_opcode;
		logic       was_masked;
		logic       last_of_frame;
	} wsfd_result_t;

endpackage
`default_nettype wire

// ----- sv/websocket_frame_decoder_core.sv -----
// Path: an accepted byte is held in the input register; its word, if any, is then
// registered into the result register, from which it is offered on out_valid.
// Throughput: one byte per cycle. A stalled result word lets one more byte into the
// input register, then in_ready drops (it follows out_ready combinationally). The
// 64-bit length count and header parse sit in one stage between the two registers.
// Reset (arst_n low, asynchronous): parser returns to the first header byte,
// all stage and result valids clear. Parser state also resets at buffer end.
`default_nettype none
module websocket_frame_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_buffer,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      payload_byte,
	output logic            final_fragment,
	output logic [2:0]      reserved_bits,
	output logic [3:0]      frame_opcode,
	output logic            was_masked,
	output logic            last_of_frame
);
	import wsfd_pkg::*;

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         eob_s1;
	wsfd_state_t  state_q;
	wsfd_state_t  state_next;
	logic         res_valid;
	wsfd_result_t res;
	logic         out_valid_q;
	wsfd_result_t res_q;
	logic         advance;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	wsfd_step u_step (
		.state         (state_q),
		.data_byte     (data_s1),
		.end_of_buffer (eob_s1),
		.state_next    (state_next),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_next;
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eob_s1 <= end_of_buffer;
		end
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign final_fragment = res_q.final_fragment;
	assign reserved_bits = res_q.reserved_bits;
	assign frame_opcode = res_q.frame_opcode;
	assign was_masked = res_q.was_masked;
	assign last_of_frame = res_q.last_of_frame;

endmodule
`default_nettype wire

// ----- sv/wsfd_step.sv -----
`default_nettype none
module wsfd_step (
	input  wsfd_pkg::wsfd_state_t  state,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_buffer,
	output wsfd_pkg::wsfd_state_t  state_next,
	output logic                   res_valid,
	output wsfd_pkg::wsfd_result_t res
);
	import wsfd_pkg::*;

	always_comb begin
		wsfd_state_t st;
		logic        emit;
		kind_t       knd;
		logic [7:0]  val;
		logic        last;
		logic [2:0]  lim;
		logic [7:0]  kbyte;

		st = state;
		emit = 1'b0;
		knd = KIND_BYTE;
		val = 8'd0;
		last = 1'b0;
		lim = (state.phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
		case (state.key_index)
			2'd0: kbyte = state.mask_key[31:24];
			2'd1: kbyte = state.mask_key[23:16];
			2'd2: kbyte = state.mask_key[15:8];
			default: kbyte = state.mask_key[7:0];
		endcase

		case (state.phase)
			PH_HDR0: begin
				st.header_bits = data_byte;
				st.phase = PH_HDR1;
			end
			PH_HDR1: begin
				st.mask_flag = data_byte[7];
				st.field_byte_count = 3'd0;
				st.remaining_length = 64'd0;
				if (data_byte[6:0] == LEN_EXT16) begin
					st.phase = PH_EXT16;
				end else if (data_byte[6:0] == LEN_EXT64) begin
					st.phase = PH_EXT64;
				end else begin
					st.remaining_length = {57'd0, data_byte[6:0]};
					if (data_byte[7]) begin
						st.phase = PH_KEY;
					end else if (data_byte[6:0] == 7'd0) begin
						st.phase = PH_DONE;
						emit = 1'b1;
						knd = KIND_EMPTY;
						last = 1'b1;
					end else begin
						st.phase = PH_DATA;
					end
				end
			end
			PH_EXT16, PH_EXT64: begin
				st.remaining_length = {state.remaining_length[55:0], data_byte};
				if (state.field_byte_count >= lim) begin
					st.field_byte_count = 3'd0;
					if (state.mask_flag) begin
						st.phase = PH_KEY;
					end else if (st.remaining_length == 64'd0) begin
						st.phase = PH_DONE;
						emit = 1'b1;
						knd = KIND_EMPTY;
						last = 1'b1;
					end else begin
						st.phase = PH_DATA;
					end
				end else begin
					st.field_byte_count = state.field_byte_count + 3'd1;
				end
			end
			PH_KEY: begin
				st.mask_key = {state.mask_key[23:0], data_byte};
				if (state.field_byte_count >= KEY_LAST) begin
					st.field_byte_count = 3'd0;
					st.key_index = 2'd0;
					if (state.remaining_length == 64'd0) begin
						st.phase = PH_DONE;
						emit = 1'b1;
						knd = KIND_EMPTY;
						last = 1'b1;
					end else begin
						st.phase = PH_DATA;
					end
				end else begin
					st.field_byte_count = state.field_byte_count + 3'd1;
				end
			end
			PH_DATA: begin
				val = data_byte;
				if (state.mask_flag) begin
					val = data_byte ^ kbyte;
					st.key_index = state.key_index + 2'd1;
				end
				st.remaining_length = state.remaining_length - 64'd1;
				emit = 1'b1;
				knd = KIND_BYTE;
				last = (state.remaining_length == 64'd1);
				if (last) begin
					st.phase = PH_DONE;
				end
			end
			default: begin
				st.phase = PH_DONE;
			end
		endcase

		res.kind = knd;
		res.payload_byte = val;
		res.final_fragment = st.header_bits[7];
		res.reserved_bits = st.header_bits[6:4];
		res.frame_opcode = st.header_bits[3:0];
		res.was_masked = st.mask_flag;
		res.last_of_frame = last;

		if (end_of_buffer) begin
			// frame not finished by buffer end: error word replaces anything else
			if (st.phase != PH_DONE) begin
				emit = 1'b1;
				res = '0;
				res.kind = KIND_ERROR;
				res.last_of_frame = 1'b1;
			end
			st = STATE_RESET;
		end

		state_next = st;
		res_valid = emit;
	end

endmodule
`default_nettype wire

// ----- sv/wsfd_checker.sv -----
`default_nettype none
module wsfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] payload_byte,
	input wire logic       final_fragment,
	input wire logic [2:0] reserved_bits,
	input wire logic [3:0] frame_opcode,
	input wire logic       was_masked,
	input wire logic       last_of_frame
);
	import wsfd_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
			&& $stable(last_of_frame))
		else $error("result word changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_BYTE || kind == KIND_EMPTY || kind == KIND_ERROR)
		else $error("illegal result kind");

	a_end_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> last_of_frame && payload_byte == 8'd0)
		else $error("empty or error word without last mark");

	a_error_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> !final_fragment && reserved_bits == 3'd0
			&& frame_opcode == 4'd0 && !was_masked)
		else $error("error word carries header fields");

endmodule

bind websocket_frame_decoder_core wsfd_checker u_wsfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.payload_byte   (payload_byte),
	.final_fragment (final_fragment),
	.reserved_bits  (reserved_bits),
	.frame_opcode   (frame_opcode),
	.was_masked     (was_masked),
	.last_of_frame  (last_of_frame)
);
`default_nettype wire

// ----- bench/websocket_frame_decoder_core_tb.sv -----
`timescale 1ns / 1ps
module websocket_frame_decoder_core_tb;
	import wsfd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int STIM_BYTES = 1330;
	localparam int CALM_FROM = 1000;
	localparam int CALM_TO = 1400;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 250;

	typedef enum int {BUF_GOOD, BUF_CUT, BUF_NOISE} buf_mode_t;
	typedef logic [7:0] byte_q_t [$];
	typedef struct packed {
		logic [7:0] data;
		logic       eob;
	} rx_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       end_of_buffer = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic       final_fragment;
	logic [2:0] reserved_bits;
	logic [3:0] frame_opcode;
	logic       was_masked;
	logic       last_of_frame;

	websocket_frame_decoder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.final_fragment(final_fragment),
		.reserved_bits(reserved_bits),
		.frame_opcode(frame_opcode),
		.was_masked(was_masked),
		.last_of_frame(last_of_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rx_byte_t     pending_bytes [$];
	wsfd_result_t expected_words [$];
	wsfd_state_t  parser = STATE_RESET;
	int           errors = 0;
	int           cyc = 0;
	int           quiet = 0;
	logic         in_fire = 1'b0;
	logic         calm;
	int           rx_cyc = 0;
	int           hold_left = 0;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	// ---------------- frame parser prediction ----------------

	function automatic wsfd_result_t frame_word(kind_t k, logic [7:0] v, logic last);
		wsfd_result_t r;
		r.kind = k;
		r.payload_byte = v;
		r.final_fragment = parser.header_bits[7];
		r.reserved_bits = parser.header_bits[6:4];
		r.frame_opcode = parser.header_bits[3:0];
		r.was_masked = parser.mask_flag;
		r.last_of_frame = last;
		return r;
	endfunction

	// length known: go to the key, the payload, or report an empty frame
	function automatic bit length_done(output wsfd_result_t r);
		r = '0;
		parser.field_byte_count = 3'd0;
		if (parser.mask_flag) begin
			parser.phase = PH_KEY;
			return 1'b0;
		end
		if (parser.remaining_length == 64'd0) begin
			parser.phase = PH_DONE;
			r = frame_word(KIND_EMPTY, 8'd0, 1'b1);
			return 1'b1;
		end
		parser.phase = PH_DATA;
		return 1'b0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eob,
			output bit got, output wsfd_result_t r);
		logic [2:0] lim;
		logic [7:0] v;
		got = 1'b0;
		r = '0;
		case (parser.phase)
			PH_HDR0: begin
				parser.header_bits = b;
				parser.phase = PH_HDR1;
			end
			PH_HDR1: begin
				parser.mask_flag = b[7];
				parser.field_byte_count = 3'd0;
				parser.remaining_length = 64'd0;
				if (b[6:0] == LEN_EXT16) begin
					parser.phase = PH_EXT16;
				end else if (b[6:0] == LEN_EXT64) begin
					parser.phase = PH_EXT64;
				end else begin
					parser.remaining_length = {57'd0, b[6:0]};
					got = length_done(r);
				end
			end
			PH_EXT16, PH_EXT64: begin
				lim = (parser.phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
				parser.remaining_length = {parser.remaining_length[55:0], b};
				if (parser.field_byte_count >= lim)
					got = length_done(r);
				else
					parser.field_byte_count = parser.field_byte_count + 3'd1;
			end
			PH_KEY: begin
				parser.mask_key = {parser.mask_key[23:0], b};
				if (parser.field_byte_count >= KEY_LAST) begin
					parser.field_byte_count = 3'd0;
					parser.key_index = 2'd0;
					if (parser.remaining_length == 64'd0) begin
						parser.phase = PH_DONE;
						r = frame_word(KIND_EMPTY, 8'd0, 1'b1);
						got = 1'b1;
					end else begin
						parser.phase = PH_DATA;
					end
				end else begin
					parser.field_byte_count = parser.field_byte_count + 3'd1;
				end
			end
			PH_DATA: begin
				v = b;
				if (parser.mask_flag) begin
					// key byte 0 sits in the top bits
					v = v ^ parser.mask_key[8 * (3 - int'(parser.key_index)) +: 8];
					parser.key_index = parser.key_index + 2'd1;
				end
				parser.remaining_length = parser.remaining_length - 64'd1;
				if (parser.remaining_length == 64'd0) begin
					parser.phase = PH_DONE;
					r = frame_word(KIND_BYTE, v, 1'b1);
				end else begin
					r = frame_word(KIND_BYTE, v, 1'b0);
				end
				got = 1'b1;
			end
			default: parser.phase = PH_DONE;
		endcase
		if (eob) begin
			// truncated frame: the error replaces whatever this byte gave
			if (parser.phase != PH_DONE) begin
				r = '0;
				r.kind = KIND_ERROR;
				r.last_of_frame = 1'b1;
				got = 1'b1;
			end
			parser = STATE_RESET;
		end
	endfunction

	// ---------------- stimulus ----------------

	task automatic send_buffer(input byte_q_t bq);
		rx_byte_t w;
		foreach (bq[i]) begin
			w.data = bq[i];
			w.eob = (i == bq.size() - 1);
			pending_bytes.insert(pending_bytes.size(), w);
		end
	endtask

	task automatic add_buffer(input buf_mode_t mode);
		byte_q_t     bq;
		logic [63:0] plen;
		logic        m;
		int          form;
		int          nbody;
		int          n;
		bq = {};
		if (mode == BUF_NOISE) begin
			repeat ($urandom_range(1, 6)) bq.insert(bq.size(), 8'($urandom));
		end else begin
			bq.insert(bq.size(), 8'($urandom));
			m = 1'($urandom_range(0, 1));
			form = $urandom_range(0, 9);
			if (form < 6) begin
				plen = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
					: $urandom_range(0, 12));
				bq.insert(bq.size(), {m, plen[6:0]});
			end else if (form < 8) begin
				if ($urandom_range(0, 19) == 0)
					plen = 64'((mode == BUF_CUT) ? $urandom_range(0, 65535)
						: $urandom_range(126, 300));
				else
					plen = 64'($urandom_range(0, 16));
				bq.insert(bq.size(), {m, LEN_EXT16});
				bq.insert(bq.size(), plen[15:8]);
				bq.insert(bq.size(), plen[7:0]);
			end else begin
				if (mode == BUF_CUT && $urandom_range(0, 1) == 1)
					plen = {$urandom, $urandom};
				else
					plen = 64'($urandom_range(0, 16));
				bq.insert(bq.size(), {m, LEN_EXT64});
				for (int i = 7; i >= 0; i--) bq.insert(bq.size(), plen[8 * i +: 8]);
			end
			if (m) repeat (4) bq.insert(bq.size(), 8'($urandom));
			nbody = (mode == BUF_CUT && plen > 64'd40) ? $urandom_range(0, 8) : int'(plen);
			repeat (nbody) bq.insert(bq.size(), 8'($urandom));
			if (mode == BUF_GOOD) begin
				// bytes after a complete frame are dropped
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3))
					bq.insert(bq.size(), 8'($urandom));
			end else begin
				n = (64'(nbody) < plen) ? $urandom_range(1, bq.size())
					: $urandom_range(1, bq.size() - 1);
				while (bq.size() > n) void'(bq.pop_back());
			end
		end
		send_buffer(bq);
	endtask

	// ---------------- sender ----------------

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
				in_valid <= 1'b1;
				data_byte <= pending_bytes[0].data;
				end_of_buffer <= pending_bytes[0].eob;
				void'(pending_bytes.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		rx_cyc = rx_cyc + 1;
		if (rx_cyc == HOLD_AT) hold_left = HOLD_LEN;
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 21);
		end
	end

	// ---------------- monitor ----------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : mon
		wsfd_result_t r;
		wsfd_result_t e;
		bit           got;
		cyc <= cyc + 1;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				decode_byte(data_byte, end_of_buffer, got, r);
				if (got) expected_words.insert(expected_words.size(), r);
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, got kind %0d byte %0h",
						$time, kind, payload_byte);
					errors++;
				end else begin
					e = expected_words.pop_front();
					check_field("kind", 8'(e.kind), 8'(kind));
					check_field("payload_byte", e.payload_byte, payload_byte);
					check_field("final_fragment", 8'(e.final_fragment), 8'(final_fragment));
					check_field("reserved_bits", 8'(e.reserved_bits), 8'(reserved_bits));
					check_field("frame_opcode", 8'(e.frame_opcode), 8'(frame_opcode));
					check_field("was_masked", 8'(e.was_masked), 8'(was_masked));
					check_field("last_of_frame", 8'(e.last_of_frame), 8'(last_of_frame));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("websocket_frame_decoder_core_tb: FAIL");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin : seq
		byte_q_t   bq;
		int        pick;
		buf_mode_t mode;
		// lone byte: truncated in the first header byte
		bq = {8'h00};
		send_buffer(bq);
		// all header bits set, masked, zero length: empty frame on last key byte
		bq = {8'hFF, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_buffer(bq);
		// unmasked empty frame, then a dropped trailing byte
		bq = {8'h00, 8'h00, 8'hAA};
		send_buffer(bq);
		// 64-bit length with its top bit set, cut in the payload
		bq = {8'h70, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h3C};
		send_buffer(bq);
		// one unmasked payload byte
		bq = {8'h81, 8'h01, 8'h41};
		send_buffer(bq);
		while (pending_bytes.size() < STIM_BYTES) begin
			pick = $urandom_range(0, 99);
			mode = (pick < 70) ? BUF_GOOD : (pick < 90) ? BUF_CUT : BUF_NOISE;
			add_buffer(mode);
		end
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (20) @(negedge clk);
		if (expected_words.size() != 0)
			$display("%0t: missing words: expected %0d more, got 0", $time,
				expected_words.size());
		if (errors == 0 && expected_words.size() == 0)
			$display("websocket_frame_decoder_core_tb: PASS");
		else
			$display("websocket_frame_decoder_core_tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/wsfd_pkg.sv
sv/wsfd_step.sv
sv/websocket_frame_decoder_core.sv
sv/wsfd_checker.sv
bench/websocket_frame_decoder_core_tb.sv
